// ----- src/lsc_pkg.sv -----
// Shared types and fixed-point constants for the Legendre series evaluator.
// Used by lsc_mul and by the top level; depends on nothing.

package lsc_pkg;

    localparam int FRAC_W   = 16;
    localparam int DATA_W   = 48;
    localparam int COEF_W   = 32;
    localparam int PT_W     = 20;
    localparam int IDX_W    = 10;
    localparam int ORD_W    = 4;
    localparam int RATIO_W  = 18;
    localparam int HALF_W   = 24;
    localparam int PP_W     = HALF_W + 1 + PT_W;
    localparam int FULL_W   = DATA_W + PT_W;
    localparam int MRES_W   = FULL_W - FRAC_W;
    localparam int WIDE_W   = MRES_W + 2;
    localparam int Q16_ONE  = 1 << FRAC_W;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    typedef struct packed {
        logic                       mode;
        logic [IDX_W-1:0]           coef_index;
        logic signed [COEF_W-1:0]   coef_value;
        logic signed [PT_W-1:0]     point;
        logic [ORD_W-1:0]           order;
        logic [IDX_W-1:0]           base_offset;
    } in_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]   sum_value;
        logic                       overflow;
        logic                       range_error;
    } result_t;

    typedef struct packed {
        logic                       start;
        logic signed [DATA_W-1:0]   a;
        logic signed [PT_W-1:0]     b;
    } mul_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [MRES_W-1:0]   value;
    } mul_rsp_t;

endpackage

// ----- src/legendre_series_clenshaw_eval.sv -----
// Top level of the Legendre series evaluator: coefficient RAM, ratio ROM and
// the Clenshaw sequencer around one shared multiplier. Depends on lsc_pkg,
// lsc_ram and lsc_mul.
//
// A write request (mode 0) stores one Q15.16 coefficient and is taken without
// a result. An evaluation request (mode 1) returns sum c[base+k]*P_k(x) for
// k = 0..n in Q31.16 and holds the input closed until its result is
// registered. Each backward step of the recurrence has an issue state, three
// passes through the shared multiplier and an update state. The next request
// is taken while a result still waits on the output, but a finished
// evaluation waits for that result to leave before its own is registered.

module legendre_series_clenshaw_eval #(
    parameter int MAX_ORDER  = 15,
    parameter int COEF_DEPTH = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lsc_pkg::in_req_t s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output lsc_pkg::result_t m_payload
);
    import lsc_pkg::*;

    localparam int AW = $clog2(COEF_DEPTH);
    localparam int KW = $clog2(MAX_ORDER + 1);
    localparam int ROM_N = 2 ** KW;

    localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'((64'sd1 <<< (DATA_W - 1)) - 1);
    localparam logic signed [WIDE_W-1:0] SAT_LO = -WIDE_W'(64'sd1 <<< (DATA_W - 1));

    typedef enum logic [3:0] {
        S_IDLE,
        S_TOP,
        S_TOPW,
        S_STEP,
        S_M1,
        S_M2,
        S_M3,
        S_UPD,
        S_LAST,
        S_LW,
        S_OUT
    } state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     ovf;
    } sat_t;

    function automatic sat_t sat48(input logic signed [WIDE_W-1:0] v);
        sat_t r;
        r.ovf = 1'b0;
        r.val = v[DATA_W-1:0];
        if (v > SAT_HI) begin
            r.val = SAT_HI[DATA_W-1:0];
            r.ovf = 1'b1;
        end else if (v < SAT_LO) begin
            r.val = SAT_LO[DATA_W-1:0];
            r.ovf = 1'b1;
        end
        return r;
    endfunction

    state_t                    state_reg, state_next;
    logic signed [PT_W-1:0]    x_reg, x_next;
    logic [KW-1:0]             n_reg, n_next;
    logic [IDX_W-1:0]          base_reg, base_next;
    logic [KW-1:0]             k_reg, k_next;
    logic signed [DATA_W-1:0]  near_reg, near_next;
    logic signed [DATA_W-1:0]  far_reg, far_next;
    logic signed [DATA_W-1:0]  p_reg, p_next;
    logic signed [DATA_W-1:0]  q_reg, q_next;
    logic signed [DATA_W-1:0]  sum_reg, sum_next;
    logic                      ovf_reg, ovf_next;
    logic                      rerr_reg, rerr_next;
    logic                      m_valid_reg, m_valid_next;
    result_t                   m_payload_reg, m_payload_next;

    logic [RATIO_W-1:0]        rom_a [ROM_N];
    logic [RATIO_W-1:0]        rom_b [ROM_N];

    logic                      s_fire;
    logic [KW-1:0]             n_in;
    logic                      range_hit;
    logic                      wr_en;
    logic                      rd_en;
    logic [KW-1:0]             rd_k;
    logic [AW-1:0]             rd_addr;
    logic [COEF_W-1:0]         rd_data;
    logic signed [DATA_W-1:0]  coef;
    mul_req_t                  mul_req;
    mul_rsp_t                  mul_rsp;
    sat_t                      sat_mul;
    sat_t                      sat_upd;
    sat_t                      sat_fin;

    for (genvar gk = 0; gk < ROM_N; gk++) begin : g_ratio
        localparam int AVAL = ((2 * gk + 1) * Q16_ONE + (gk + 1) / 2) / (gk + 1);
        localparam int BVAL = ((gk + 1) * Q16_ONE + (gk + 2) / 2) / (gk + 2);
        assign rom_a[gk] = RATIO_W'(AVAL);
        assign rom_b[gk] = RATIO_W'(BVAL);
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    assign n_in      = (32'(s_payload.order) > MAX_ORDER) ? KW'(MAX_ORDER)
                                                          : KW'(s_payload.order);
    assign range_hit = (32'(s_payload.base_offset) + 32'(n_in)) >= 32'(COEF_DEPTH);
    assign wr_en     = s_fire && (s_payload.mode == MODE_WRITE)
                       && (32'(s_payload.coef_index) < 32'(COEF_DEPTH));

    assign rd_en   = (state_reg == S_TOP) || (state_reg == S_STEP) || (state_reg == S_LAST);
    assign rd_k    = (state_reg == S_TOP) ? n_reg
                   : (state_reg == S_STEP) ? k_reg : '0;
    assign rd_addr = AW'(32'(base_reg) + 32'(rd_k));
    assign coef    = DATA_W'($signed(rd_data));

    assign sat_mul = sat48(WIDE_W'(mul_rsp.value));
    assign sat_upd = sat48(WIDE_W'(p_reg) - WIDE_W'(q_reg) + WIDE_W'(coef));
    assign sat_fin = sat48(WIDE_W'(coef) + WIDE_W'(mul_rsp.value)
                           - WIDE_W'(far_reg >>> 1));

    lsc_ram #(
        .WIDTH (COEF_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(s_payload.coef_index)),
        .wr_data (s_payload.coef_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lsc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    always_comb begin
        state_next     = state_reg;
        x_next         = x_reg;
        n_next         = n_reg;
        base_next      = base_reg;
        k_next         = k_reg;
        near_next      = near_reg;
        far_next       = far_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        sum_next       = sum_reg;
        ovf_next       = ovf_reg;
        rerr_next      = rerr_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        mul_req.start  = 1'b0;
        mul_req.a      = near_reg;
        mul_req.b      = x_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_fire && s_payload.mode == MODE_EVAL) begin
                    x_next    = s_payload.point;
                    n_next    = n_in;
                    base_next = s_payload.base_offset;
                    ovf_next  = 1'b0;
                    if (range_hit) begin
                        sum_next   = '0;
                        rerr_next  = 1'b1;
                        state_next = S_OUT;
                    end else begin
                        rerr_next  = 1'b0;
                        state_next = S_TOP;
                    end
                end
            end
            S_TOP: begin
                state_next = S_TOPW;
            end
            S_TOPW: begin
                near_next = coef;
                far_next  = '0;
                if (n_reg == '0) begin
                    sum_next   = coef;
                    k_next     = '0;
                    state_next = S_OUT;
                end else begin
                    k_next     = n_reg - KW'(1);
                    state_next = (n_reg == KW'(1)) ? S_LAST : S_STEP;
                end
            end
            S_STEP: begin
                mul_req.start = 1'b1;
                state_next    = S_M1;
            end
            S_M1: begin
                if (mul_rsp.done) begin
                    ovf_next      = ovf_reg | sat_mul.ovf;
                    mul_req.start = 1'b1;
                    mul_req.a     = sat_mul.val;
                    mul_req.b     = PT_W'(rom_a[k_reg]);
                    state_next    = S_M2;
                end
            end
            S_M2: begin
                if (mul_rsp.done) begin
                    ovf_next      = ovf_reg | sat_mul.ovf;
                    p_next        = sat_mul.val;
                    mul_req.start = 1'b1;
                    mul_req.a     = far_reg;
                    mul_req.b     = PT_W'(rom_b[k_reg]);
                    state_next    = S_M3;
                end
            end
            S_M3: begin
                if (mul_rsp.done) begin
                    ovf_next   = ovf_reg | sat_mul.ovf;
                    q_next     = sat_mul.val;
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                ovf_next   = ovf_reg | sat_upd.ovf;
                near_next  = sat_upd.val;
                far_next   = near_reg;
                k_next     = k_reg - KW'(1);
                state_next = (k_reg == KW'(1)) ? S_LAST : S_STEP;
            end
            S_LAST: begin
                mul_req.start = 1'b1;
                state_next    = S_LW;
            end
            S_LW: begin
                if (mul_rsp.done) begin
                    ovf_next   = ovf_reg | sat_fin.ovf;
                    sum_next   = sat_fin.val;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_payload_next.sum_value   = sum_reg;
                    m_payload_next.overflow    = ovf_reg;
                    m_payload_next.range_error = rerr_reg;
                    state_next                 = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
            near_reg    <= '0;
            far_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            k_reg       <= k_next;
            near_reg    <= near_next;
            far_reg     <= far_next;
        end
        x_reg         <= x_next;
        n_reg         <= n_next;
        base_reg      <= base_next;
        p_reg         <= p_next;
        q_reg         <= q_next;
        sum_reg       <= sum_next;
        ovf_reg       <= ovf_next;
        rerr_reg      <= rerr_next;
        m_payload_reg <= m_payload_next;
    end

    a_done_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> (state_reg == S_M1 || state_reg == S_M2
                          || state_reg == S_M3 || state_reg == S_LW))
        else $error("Multiplier result arrived outside a wait state.");

    a_counter_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> k_reg == '0)
        else $error("Order counter not cleared between requests.");

    a_range_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.range_error) |-> (m_payload.sum_value == '0
                                                && !m_payload.overflow))
        else $error("Range error result carries a value.");

    a_no_read_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> !wr_en)
        else $error("Coefficient read and write in the same cycle.");

endmodule

// ----- src/lsc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.

module lsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- src/lsc_mul.sv -----
// Shared Q.16 multiplier: 48-bit by 20-bit product from two partial products of
// its 24-bit halves, rounded to nearest. Depends on lsc_pkg.

module lsc_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  lsc_pkg::mul_req_t req,
    output lsc_pkg::mul_rsp_t rsp
);
    import lsc_pkg::*;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_LO,
        MUL_HI,
        MUL_DONE
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic signed [DATA_W-1:0]  a_reg;
    logic signed [PT_W-1:0]    b_reg;
    logic signed [PP_W-1:0]    lo_reg;
    logic signed [PP_W-1:0]    hi_reg;
    logic signed [HALF_W:0]    op_a;
    logic signed [PP_W-1:0]    product;
    logic signed [FULL_W-1:0]  full;

    assign op_a    = (phase_reg == MUL_LO) ? $signed({1'b0, a_reg[HALF_W-1:0]})
                                           : $signed({a_reg[DATA_W-1], a_reg[DATA_W-1:HALF_W]});
    assign product = PP_W'(op_a * b_reg);
    assign full    = (FULL_W'(hi_reg) <<< HALF_W) + FULL_W'(lo_reg)
                   + FULL_W'(Q16_ONE / 2);

    assign rsp.done  = (phase_reg == MUL_DONE);
    assign rsp.value = full[FULL_W-1:FRAC_W];

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            MUL_IDLE: phase_next = req.start ? MUL_LO : MUL_IDLE;
            MUL_LO:   phase_next = MUL_HI;
            MUL_HI:   phase_next = MUL_DONE;
            MUL_DONE: phase_next = req.start ? MUL_LO : MUL_IDLE;
            default:  phase_next = MUL_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= MUL_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
        if (req.start) begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        if (phase_reg == MUL_LO) begin
            lo_reg <= product;
        end
        if (phase_reg == MUL_HI) begin
            hi_reg <= product;
        end
    end

    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> (phase_reg == MUL_IDLE || phase_reg == MUL_DONE))
        else $error("Multiplier started while busy.");

    a_done_follows_hi: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == MUL_HI |=> rsp.done)
        else $error("Multiplier result did not follow the high partial product.");

    a_lo_needs_start: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == MUL_LO |-> $past(req.start))
        else $error("Multiplier ran without a start.");

endmodule

// ----- verif/legendre_series_clenshaw_eval_tb.sv -----
// Self-checking testbench for legendre_series_clenshaw_eval. It sends coefficient writes and
// series evaluation requests with random gaps and output stalls, and checks every sum against
// a fixed-point Clenshaw predictor kept here. Depends on lsc_pkg and the RTL only.

module legendre_series_clenshaw_eval_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lsc_pkg::*;

    localparam int     MAX_ORDER  = 15;
    localparam int     COEF_DEPTH = 1024;
    localparam longint SAT_HI     = 64'sh7FFF_FFFF_FFFF;
    localparam longint SAT_LO     = -SAT_HI - 1;

    logic    aclk      = 1'b0;
    logic    aresetn   = 1'b0;
    logic    s_valid   = 1'b0;
    logic    s_ready;
    in_req_t s_payload = '0;
    logic    m_valid;
    logic    m_ready   = 1'b0;
    result_t m_payload;

    logic signed [COEF_W-1:0] coef_image [COEF_DEPTH];
    bit                       coef_written [COEF_DEPTH];
    result_t                  pending_sums [$];
    bit                       quiet_tail;
    int                       error_count, requests_sent, sums_checked;
    int                       sums_saturated, sums_out_of_range;

    legendre_series_clenshaw_eval #(
        .MAX_ORDER (MAX_ORDER),
        .COEF_DEPTH(COEF_DEPTH)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint round_mul(longint a, longint b);
        longint hi, lo;
        hi = a >>> FRAC_W;
        lo = a - (hi <<< FRAC_W);
        return hi * b + ((lo * b + (Q16_ONE / 2)) >>> FRAC_W);
    endfunction

    function automatic longint clamp48(longint v, inout bit ovf);
        if (v > SAT_HI) begin
            ovf = 1'b1;
            return SAT_HI;
        end
        if (v < SAT_LO) begin
            ovf = 1'b1;
            return SAT_LO;
        end
        return v;
    endfunction

    function automatic longint ratio_q16(int num, int den);
        return ((longint'(num) <<< FRAC_W) + den / 2) / den;
    endfunction

    function automatic in_req_t scrambled_req();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(in_req_t)-1:0];
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        endcase
    endfunction

    function automatic logic signed [PT_W-1:0] rand_point();
        case ($urandom_range(0, 5))
            0:       return PT_W'($urandom);
            1:       return $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
            default: return PT_W'($signed($urandom_range(0, 2 * Q16_ONE)) - Q16_ONE);
        endcase
    endfunction

    function automatic int rand_order();
        return ($urandom_range(0, 3) == 0) ? MAX_ORDER : $urandom_range(0, MAX_ORDER);
    endfunction

    task automatic send_req(input in_req_t req);
        result_t want;
        longint  x, y1, y2, p, q, total;
        bit      ovf;
        int      n, base;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= req;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        if (req.mode == MODE_WRITE) begin
            coef_image[req.coef_index]   = req.coef_value;
            coef_written[req.coef_index] = 1'b1;
        end else begin
            want = '0;
            n    = (int'(req.order) > MAX_ORDER) ? MAX_ORDER : int'(req.order);
            base = int'(req.base_offset);
            ovf  = 1'b0;
            if (base + n >= COEF_DEPTH) begin
                want.range_error = 1'b1;
                sums_out_of_range++;
            end else if (n == 0) begin
                total          = longint'(coef_image[base]);
                want.sum_value = total[DATA_W-1:0];
            end else begin
                x  = longint'(req.point);
                y1 = longint'(coef_image[base + n]);
                y2 = 0;
                for (int k = n - 1; k > 0; k--) begin
                    p  = clamp48(round_mul(y1, x), ovf);
                    p  = clamp48(round_mul(p, ratio_q16(2 * k + 1, k + 1)), ovf);
                    q  = clamp48(round_mul(y2, ratio_q16(k + 1, k + 2)), ovf);
                    y2 = y1;
                    y1 = clamp48(p - q + longint'(coef_image[base + k]), ovf);
                end
                total = clamp48(longint'(coef_image[base]) + round_mul(x, y1) - (y2 >>> 1),
                                ovf);
                want.sum_value = total[DATA_W-1:0];
                want.overflow  = ovf;
                if (ovf) sums_saturated++;
            end
            pending_sums.push_back(want);
        end
    endtask

    task automatic send_write(int idx, logic signed [COEF_W-1:0] val);
        in_req_t req;
        req            = scrambled_req();
        req.mode       = MODE_WRITE;
        req.coef_index = IDX_W'(idx);
        req.coef_value = val;
        send_req(req);
    endtask

    task automatic send_eval(logic signed [PT_W-1:0] x, int n, int base);
        in_req_t req;
        req             = scrambled_req();
        req.mode        = MODE_EVAL;
        req.point       = x;
        req.order       = ORD_W'(n);
        req.base_offset = IDX_W'(base);
        send_req(req);
    endtask

    task automatic wait_for_sums();
        s_valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_write(0, 32'sh7FFF_FFFF);
        send_write(1, 32'sh7FFF_FFFF);
        send_write(2, 32'sh8000_0000);
        send_write(3, 32'sh0001_0000);
        send_write(1020, 32'sh0000_0000);
        send_write(1021, 32'sh0001_0000);
        send_write(1022, -32'sh0000_8000);
        send_write(1023, 32'sh0003_0000);
        send_eval(20'sh00000, 0, 0);
        send_eval(20'sh7FFFF, 3, 0);
        send_eval(20'sh80000, 3, 0);
        send_eval(20'sh10000, 3, 1020);
        send_eval(-20'sh10000, 3, 1020);
        send_eval(20'sh08000, 1, 1022);
        send_eval(20'sh7FFFF, 0, 1023);
        send_eval(20'sh12345, 1, 1023);
        send_eval(20'sh00000, 15, 1009);
        send_eval(20'sh80000, 15, 1023);
    endtask

    task automatic test_series_sequences(int upto);
        int n, base;
        while (requests_sent < upto) begin
            n    = rand_order();
            base = ($urandom_range(0, 7) == 0) ? COEF_DEPTH - 1 - n
                                                : $urandom_range(0, COEF_DEPTH - 1 - n);
            for (int k = base; k <= base + n; k++) begin
                if (!coef_written[k] || $urandom_range(0, 2) == 0) send_write(k, rand_coef());
            end
            repeat ($urandom_range(1, 3)) send_eval(rand_point(), n, base);
        end
        wait_for_sums();
    endtask

    task automatic test_mixed_noise(int upto);
        int n, base, k;
        while (requests_sent < upto) begin
            n = $urandom_range(0, MAX_ORDER);
            case ($urandom_range(0, 3))
                0: begin
                    send_write($urandom_range(0, COEF_DEPTH - 1), rand_coef());
                    continue;
                end
                1:       base = $urandom_range(COEF_DEPTH - 1 - n, COEF_DEPTH - 1);
                default: base = $urandom_range(0, COEF_DEPTH - 1);
            endcase
            k = base;
            while (k <= base + n && k < COEF_DEPTH && coef_written[k]) k++;
            if (base + n >= COEF_DEPTH || k > base + n) send_eval(rand_point(), n, base);
            else send_write(k, rand_coef());
        end
    endtask

    task automatic test_quiet_tail(int upto);
        quiet_tail = 1'b1;
        test_series_sequences(upto);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_series_sequences(1150);
        test_mixed_noise(1750);
        test_quiet_tail(1900);
        repeat (200) @(posedge aclk);
        $display("Sent %0d requests; checked %0d sums, %0d saturated and %0d out of range.",
                 requests_sent, sums_checked, sums_saturated, sums_out_of_range);
        if (error_count == 0) begin
            $display("legendre_series_clenshaw_eval_tb: done, clean");
        end else begin
            $display("legendre_series_clenshaw_eval_tb: done, errors");
        end
        $finish;
    end

    initial begin : result_checker
        result_t got, want;
        int      stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got = m_payload;
                if (pending_sums.size() == 0) begin
                    error_count++;
                    $error("unexpected result: sum_value %0d, overflow %0b, range_error %0b",
                           got.sum_value, got.overflow, got.range_error);
                end else begin
                    want = pending_sums.pop_front();
                    sums_checked++;
                    if (got.sum_value !== want.sum_value) begin
                        error_count++;
                        $error("sum_value: expected %0d, got %0d", want.sum_value,
                               got.sum_value);
                    end
                    if (got.overflow !== want.overflow) begin
                        error_count++;
                        $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                    end
                    if (got.range_error !== want.range_error) begin
                        error_count++;
                        $error("range_error: expected %0b, got %0b", want.range_error,
                               got.range_error);
                    end
                end
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
                m_ready    <= 1'b0;
                stall_left = $urandom_range(1, 7) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #20_000_000;
        $display("legendre_series_clenshaw_eval_tb: done, errors");
        $finish;
    end

endmodule

// ----- legendre_series_clenshaw_eval.f -----
src/lsc_pkg.sv
src/lsc_ram.sv
src/lsc_mul.sv
src/legendre_series_clenshaw_eval.sv
verif/legendre_series_clenshaw_eval_tb.sv
